// ----- rtl/ncent_pkg.sv -----
// Shared definitions for the nearest-centroid assignment block.
// Holds default sizes, port field widths, item codes, state and tag types.
// No dependencies.
`timescale 1ns / 1ps

package ncent_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_CLUSTERS_DEF = 16;
    localparam int COORD_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF   = 16;

    // Field widths fixed by the port definition.
    localparam int CFG_W      = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd10;
    localparam int MODE_W     = 2;
    localparam int SLOT_W     = 4;
    localparam int FIELD_W    = 16;
    localparam int IDX_OUT_W  = 4;
    localparam int DIST_OUT_W = 33;
    localparam int CNT_OUT_W  = 16;

    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 56;
    localparam int M_PAD_W    = M_TDATA_W - IDX_OUT_W - DIST_OUT_W - CNT_OUT_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD     = 2'd0,
        MODE_CLASSIFY = 2'd1,
        MODE_CLEAR    = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CLEAR,
        ST_SCAN,
        ST_DRAIN,
        ST_CNT_RD,
        ST_CNT_WR
    } state_t;

    // Tag that rides along with each centroid through the distance pipeline.
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } scan_tag_t;

endpackage

// ----- rtl/nearest_centroid_assign.sv -----
// Top level of the nearest-centroid assignment block (k-means assignment step).
// Uses ncent_pkg, ncent_ram (centroid table, membership counts) and ncent_dist.
`timescale 1ns / 1ps

//  Channel   Dir  Handshake            Word contents (low bits first)
//  s_*       in   s_tvalid / s_tready  tuser: mode; tdata: slot, x, y
//  m_*       out  m_tvalid / m_tready  tdata: cluster index, distance^2, count
//  cfg_*     in   cfg_wr_en            clusters_in_use, no wait, no read-back
//
//  Classify reads n centroid entries, n being the clamped cluster count: the
//  centroid memory gives one entry per cycle into a three-stage distance
//  pipeline, then the count memory takes one read and one write.
//  Reset clears control state and the per-entry valid bits at once; an entry
//  never written reads as zero, so no clearing pass runs.
//  A waiting result holds in the output register while new words are taken;
//  only the count write-back waits for that register to free up.

module nearest_centroid_assign #(
    parameter int MAX_CLUSTERS = ncent_pkg::MAX_CLUSTERS_DEF,
    parameter int COORD_BITS   = ncent_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS   = ncent_pkg::COUNT_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration: clusters_in_use
    input  logic                             cfg_wr_en,
    input  logic [ncent_pkg::CFG_W-1:0]      cfg_wr_data,
    // input words
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tdata: centroid_slot[3:0], point_x[19:4], point_y[35:20], zero pad
    input  logic [ncent_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser: mode[1:0]
    input  logic [ncent_pkg::MODE_W-1:0]     s_tuser,
    // result words
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tdata: cluster_index[3:0], distance_squared[36:4], member_count[52:37], pad
    output logic [ncent_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int IDX_W      = $clog2(MAX_CLUSTERS);
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SUM_W      = 2 * DIFF_W + 1;
    localparam int SLOT_W     = ncent_pkg::SLOT_W;
    localparam int FIELD_W    = ncent_pkg::FIELD_W;
    localparam int IDX_OUT_W  = ncent_pkg::IDX_OUT_W;
    localparam int DIST_OUT_W = ncent_pkg::DIST_OUT_W;
    localparam int CNT_OUT_W  = ncent_pkg::CNT_OUT_W;
    localparam int M_PAD_W    = ncent_pkg::M_PAD_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Input word fields
    localparam int X_LO = SLOT_W;
    localparam int Y_LO = SLOT_W + FIELD_W;

    ncent_pkg::state_t state_reg, state_next;

    logic [ncent_pkg::CFG_W-1:0] cfg_reg;

    logic [SLOT_W-1:0]     item_slot_reg;
    logic [COORD_BITS-1:0] item_x_reg;
    logic [COORD_BITS-1:0] item_y_reg;

    logic [IDX_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] scan_last_reg;
    logic [IDX_W-1:0] scan_last;

    ncent_pkg::scan_tag_t rd_tag_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic                 rd_cvld_reg;

    logic [MAX_CLUSTERS-1:0] cvld_reg;   // centroid entry written since reset
    logic [MAX_CLUSTERS-1:0] nvld_reg;   // count entry written since reset/clear

    logic [IDX_W-1:0] best_idx_reg;
    logic [SUM_W-1:0] best_d_reg;
    logic             cnt_vld_q_reg;

    logic                         m_tvalid_reg;
    logic [ncent_pkg::M_TDATA_W-1:0] m_tdata_reg;

    // FSM outputs
    logic accept;
    logic slot_ok;
    logic cent_we;
    logic cent_re;
    logic cnt_re;
    logic out_load;
    logic clear_counts;

    logic [2*COORD_BITS-1:0] cent_rdata;
    logic [COORD_BITS-1:0]   cent_x;
    logic [COORD_BITS-1:0]   cent_y;

    ncent_pkg::scan_tag_t res_tag;
    logic [IDX_W-1:0]     res_idx;
    logic [SUM_W-1:0]     res_dist;

    logic [COUNT_BITS-1:0] cnt_rdata;
    logic [COUNT_BITS-1:0] cnt_cur;
    logic [COUNT_BITS-1:0] cnt_new;

    assign accept  = s_tvalid && s_tready;
    assign slot_ok = int'(item_slot_reg) < MAX_CLUSTERS;

    // Clamp the configured cluster count into 1..MAX_CLUSTERS, kept as last index.
    always_comb begin
        if (cfg_reg == '0) begin
            scan_last = '0;
        end else if (int'(cfg_reg) >= MAX_CLUSTERS) begin
            scan_last = IDX_W'(MAX_CLUSTERS - 1);
        end else begin
            scan_last = IDX_W'(cfg_reg - 1'b1);
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ncent_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    case (ncent_pkg::mode_t'(s_tuser))
                        ncent_pkg::MODE_LOAD:     state_next = ncent_pkg::ST_LOAD;
                        ncent_pkg::MODE_CLASSIFY: state_next = ncent_pkg::ST_SCAN;
                        ncent_pkg::MODE_CLEAR:    state_next = ncent_pkg::ST_CLEAR;
                        default:                  state_next = ncent_pkg::ST_IDLE;
                    endcase
                end
            end
            ncent_pkg::ST_LOAD:  state_next = ncent_pkg::ST_IDLE;
            ncent_pkg::ST_CLEAR: state_next = ncent_pkg::ST_IDLE;
            ncent_pkg::ST_SCAN: begin
                if (scan_idx_reg == scan_last_reg) begin
                    state_next = ncent_pkg::ST_DRAIN;
                end
            end
            ncent_pkg::ST_DRAIN: begin
                // last distance leaves the pipeline: best is final next cycle
                if (res_tag.vld && res_tag.last) begin
                    state_next = ncent_pkg::ST_CNT_RD;
                end
            end
            ncent_pkg::ST_CNT_RD: state_next = ncent_pkg::ST_CNT_WR;
            ncent_pkg::ST_CNT_WR: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ncent_pkg::ST_IDLE;
                end
            end
            default: state_next = ncent_pkg::ST_IDLE;
        endcase
    end

    // FSM outputs; hold off input words while reset is applied.
    always_comb begin
        s_tready     = 1'b0;
        cent_we      = 1'b0;
        cent_re      = 1'b0;
        cnt_re       = 1'b0;
        out_load     = 1'b0;
        clear_counts = 1'b0;
        case (state_reg)
            ncent_pkg::ST_IDLE:   s_tready     = aresetn;
            ncent_pkg::ST_LOAD:   cent_we      = slot_ok;
            ncent_pkg::ST_CLEAR:  clear_counts = 1'b1;
            ncent_pkg::ST_SCAN:   cent_re      = 1'b1;
            ncent_pkg::ST_DRAIN:  ;
            ncent_pkg::ST_CNT_RD: cnt_re       = 1'b1;
            ncent_pkg::ST_CNT_WR: out_load     = !m_tvalid_reg || m_tready;
            default:              ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ncent_pkg::ST_IDLE;
            cfg_reg   <= ncent_pkg::CFG_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
        end
    end

    // Capture the accepted word; coordinates take the low COORD_BITS bits.
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_slot_reg <= s_tdata[SLOT_W-1:0];
            item_x_reg    <= COORD_BITS'(s_tdata[X_LO +: FIELD_W]);
            item_y_reg    <= COORD_BITS'(s_tdata[Y_LO +: FIELD_W]);
            scan_last_reg <= scan_last;
        end
    end

    // Advance the scan address, one centroid per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
        end else if (accept) begin
            scan_idx_reg <= '0;
        end else if (cent_re && scan_idx_reg != scan_last_reg) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
    end

    // Align tag, index and valid bit with the registered memory read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_tag_reg <= '0;
        end else begin
            rd_tag_reg.vld   <= cent_re;
            rd_tag_reg.first <= scan_idx_reg == '0;
            rd_tag_reg.last  <= scan_idx_reg == scan_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg  <= scan_idx_reg;
        rd_cvld_reg <= cvld_reg[scan_idx_reg];
    end

    // Valid bits stand in for the zero reset of both tables.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cvld_reg <= '0;
            nvld_reg <= '0;
        end else begin
            if (cent_we) begin
                cvld_reg[IDX_W'(item_slot_reg)] <= 1'b1;
            end
            if (clear_counts) begin
                nvld_reg <= '0;
            end else if (out_load) begin
                nvld_reg[best_idx_reg] <= 1'b1;
            end
        end
    end

    ncent_ram #(
        .DEPTH (MAX_CLUSTERS),
        .WIDTH (2 * COORD_BITS)
    ) u_cent_ram (
        .aclk    (aclk),
        .wr_en   (cent_we),
        .wr_addr (IDX_W'(item_slot_reg)),
        .wr_data ({item_y_reg, item_x_reg}),
        .rd_en   (cent_re),
        .rd_addr (scan_idx_reg),
        .rd_data (cent_rdata)
    );

    // Unwritten entries read as the origin.
    assign cent_x = rd_cvld_reg ? cent_rdata[COORD_BITS-1:0] : '0;
    assign cent_y = rd_cvld_reg ? cent_rdata[2*COORD_BITS-1:COORD_BITS] : '0;

    ncent_dist #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W)
    ) u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_tag   (rd_tag_reg),
        .in_idx   (rd_idx_reg),
        .px       (item_x_reg),
        .py       (item_y_reg),
        .cx       (cent_x),
        .cy       (cent_y),
        .out_tag  (res_tag),
        .out_idx  (res_idx),
        .out_dist (res_dist)
    );

    // Keep the running minimum; a strict compare leaves ties at the lower index.
    always_ff @(posedge aclk) begin
        if (res_tag.vld && (res_tag.first || res_dist < best_d_reg)) begin
            best_idx_reg <= res_idx;
            best_d_reg   <= res_dist;
        end
    end

    ncent_ram #(
        .DEPTH (MAX_CLUSTERS),
        .WIDTH (COUNT_BITS)
    ) u_cnt_ram (
        .aclk    (aclk),
        .wr_en   (out_load),
        .wr_addr (best_idx_reg),
        .wr_data (cnt_new),
        .rd_en   (cnt_re),
        .rd_addr (best_idx_reg),
        .rd_data (cnt_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cnt_re) begin
            cnt_vld_q_reg <= nvld_reg[best_idx_reg];
        end
    end

    // Saturating increment of the chosen cluster's count.
    assign cnt_cur = cnt_vld_q_reg ? cnt_rdata : '0;
    assign cnt_new = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;

    // Output register: load the result, drop valid once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {{M_PAD_W{1'b0}},
                            CNT_OUT_W'(cnt_new),
                            DIST_OUT_W'(best_d_reg),
                            IDX_OUT_W'(best_idx_reg)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A result appears only out of the count write-back step.
    a_result_from_wr : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ncent_pkg::ST_CNT_WR))
        else $error("result word raised outside count write-back");

    // The scan never runs past the clamped cluster count.
    a_scan_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ncent_pkg::ST_SCAN) |-> (scan_idx_reg <= scan_last_reg))
        else $error("scan index beyond last searched entry");

    // The chosen cluster is one of the searched entries.
    a_best_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ncent_pkg::ST_CNT_RD) |-> (best_idx_reg <= scan_last_reg))
        else $error("chosen cluster outside searched range");

    // A count write never coincides with a clear of the counts and follows a count read.
    a_no_wr_on_clear : assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !clear_counts && $past(state_reg == ncent_pkg::ST_CNT_RD ||
                                            state_reg == ncent_pkg::ST_CNT_WR))
        else $error("count write-back without a preceding count read");

endmodule

// ----- rtl/ncent_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the centroid table and the membership counts; needs ncent_pkg.
`timescale 1ns / 1ps

module ncent_ram #(
    parameter int DEPTH  = ncent_pkg::MAX_CLUSTERS_DEF,
    parameter int WIDTH  = 2 * ncent_pkg::COORD_BITS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/ncent_dist.sv -----
// Three-stage squared-distance pipeline: absolute differences, squares, sum.
// Carries the scan tag and entry index alongside; needs ncent_pkg.
`timescale 1ns / 1ps

module ncent_dist #(
    parameter int COORD_BITS = ncent_pkg::COORD_BITS_DEF,
    parameter int IDX_W      = $clog2(ncent_pkg::MAX_CLUSTERS_DEF),
    localparam int DIFF_W    = COORD_BITS + 1,
    localparam int SQ_W      = 2 * DIFF_W,
    localparam int SUM_W     = SQ_W + 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ncent_pkg::scan_tag_t  in_tag,
    input  logic [IDX_W-1:0]      in_idx,
    input  logic [COORD_BITS-1:0] px,
    input  logic [COORD_BITS-1:0] py,
    input  logic [COORD_BITS-1:0] cx,
    input  logic [COORD_BITS-1:0] cy,
    output ncent_pkg::scan_tag_t  out_tag,
    output logic [IDX_W-1:0]      out_idx,
    output logic [SUM_W-1:0]      out_dist
);

    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [DIFF_W-1:0]        ax;
    logic [DIFF_W-1:0]        ay;

    ncent_pkg::scan_tag_t tag1_reg, tag2_reg, tag3_reg;
    logic [IDX_W-1:0]     idx1_reg, idx2_reg, idx3_reg;
    logic [DIFF_W-1:0]    ax_reg, ay_reg;
    logic [SQ_W-1:0]      sqx_reg, sqy_reg;
    logic [SUM_W-1:0]     sum_reg;

    // Differences are one bit wider than the coordinates, so they never overflow.
    always_comb begin
        dx = $signed({px[COORD_BITS-1], px}) - $signed({cx[COORD_BITS-1], cx});
        dy = $signed({py[COORD_BITS-1], py}) - $signed({cy[COORD_BITS-1], cy});
        ax = dx[DIFF_W-1] ? $unsigned(-dx) : $unsigned(dx);
        ay = dy[DIFF_W-1] ? $unsigned(-dy) : $unsigned(dy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end else begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        idx1_reg <= in_idx;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        ax_reg   <= ax;
        ay_reg   <= ay;
        sqx_reg  <= ax_reg * ax_reg;
        sqy_reg  <= ay_reg * ay_reg;
        sum_reg  <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
    end

    assign out_tag  = tag3_reg;
    assign out_idx  = idx3_reg;
    assign out_dist = sum_reg;

endmodule
